// File: rtl/nlt_pkg.sv
// Package for the node liveness table: shared types, codes and field widths.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps

package nlt_pkg;

	localparam int ID_W   = 5;
	localparam int EV_W   = 3;
	localparam int CNT_W  = 8;
	localparam int MODE_W = 2;
	localparam int MASK_W = 16;
	localparam int CFG_IDX_W = 2;

	localparam logic REQ_EVENT = 1'b0;
	localparam logic REQ_ROUND = 1'b1;

	localparam logic [EV_W-1:0] EV_PONG_APP   = 3'd0;
	localparam logic [EV_W-1:0] EV_PONG_BOOT  = 3'd1;
	localparam logic [EV_W-1:0] EV_DATA       = 3'd2;
	localparam logic [EV_W-1:0] EV_CERT       = 3'd3;
	localparam logic [EV_W-1:0] EV_DATA_MISS  = 3'd4;
	localparam logic [EV_W-1:0] EV_LOGIN_DONE = 3'd5;

	localparam logic [MODE_W-1:0] MODE_UNKNOWN = 2'd0;
	localparam logic [MODE_W-1:0] MODE_APP     = 2'd1;
	localparam logic [MODE_W-1:0] MODE_BOOT    = 2'd2;

	localparam logic [CFG_IDX_W-1:0] CFG_DATA_MISS_LIMIT     = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_MISSED_ROUNDS_LIMIT = 2'd1;

	localparam logic [CNT_W-1:0] CNT_MAX = 8'hFF;
	localparam logic [CNT_W-1:0] LIMIT_RESET = 8'd3;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DECODE,
		ST_EVENT,
		ST_WALK,
		ST_ROUND_OUT
	} state_t;

	typedef struct packed {
		logic              registered;
		logic              alive;
		logic [MODE_W-1:0] mode;
		logic              service;
		logic [CNT_W-1:0]  miss;
		logic [CNT_W-1:0]  silent;
		logic              responded;
		logic              cert;
		logic              logged_in;
		logic              login_wait;
		logic              logout_wait;
	} entry_t;

	typedef struct packed {
		logic latch;
		logic apply_event;
		logic first_round;
		logic walk_start;
		logic walk_step;
		logic load_round;
	} dp_cmd_t;

	typedef struct packed {
		logic req_round;
		logic first_done;
		logic walk_last;
		logic slot_free;
	} dp_status_t;

endpackage

// File: rtl/nlt_ctrl.sv
// Controller for the node liveness table: request sequencing state machine.
// Depends on nlt_pkg; drives the datapath through dp_cmd_t, reads dp_status_t.
`timescale 1ns / 1ps

module nlt_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  nlt_pkg::dp_status_t status,
	output nlt_pkg::dp_cmd_t    cmd
);
	import nlt_pkg::*;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) state_d = ST_DECODE;
			end
			ST_DECODE: begin
				if (!status.req_round) state_d = ST_EVENT;
				else if (!status.first_done) state_d = ST_ROUND_OUT;
				else state_d = ST_WALK;
			end
			ST_EVENT: begin
				if (status.slot_free) state_d = ST_IDLE;
			end
			ST_WALK: begin
				if (status.walk_last) state_d = ST_ROUND_OUT;
			end
			ST_ROUND_OUT: begin
				if (status.slot_free) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		in_stall = 1'b1;
		case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
				cmd.latch = in_valid;
			end
			ST_DECODE: begin
				cmd.first_round = status.req_round && !status.first_done;
				cmd.walk_start  = status.req_round && status.first_done;
			end
			ST_EVENT: begin
				cmd.apply_event = status.slot_free;
			end
			ST_WALK: begin
				cmd.walk_step = 1'b1;
			end
			ST_ROUND_OUT: begin
				cmd.load_round = status.slot_free;
			end
			default: begin
				in_stall = 1'b1;
			end
		endcase
	end

endmodule

// File: rtl/nlt_dp.sv
// Datapath for the node liveness table: node table, limits, walk counter, result register.
// Depends on nlt_pkg; sequenced by nlt_ctrl.
`timescale 1ns / 1ps

module nlt_dp #(
	parameter int MAX_NODES = 16
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  nlt_pkg::dp_cmd_t                  cmd,
	output nlt_pkg::dp_status_t               status,
	input  logic                              req_type,
	input  logic [nlt_pkg::ID_W-1:0]          node_id,
	input  logic [nlt_pkg::EV_W-1:0]          event_code,
	input  logic                              cert_ok,
	input  logic                              cfg_valid,
	input  logic [nlt_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [nlt_pkg::CNT_W-1:0]         cfg_data,
	input  logic                              out_stall,
	output logic                              out_valid,
	output logic [nlt_pkg::ID_W-1:0]          out_node,
	output logic                              link_alive,
	output logic [nlt_pkg::MODE_W-1:0]        node_mode,
	output logic                              service_online,
	output logic                              login_pending,
	output logic                              logout_pending,
	output logic                              cert_seen,
	output logic                              revived,
	output logic [nlt_pkg::MASK_W-1:0]        offline_mask,
	output logic [nlt_pkg::MASK_W-1:0]        event_mask
);
	import nlt_pkg::*;

	localparam int IDX_W = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
	localparam int CMP_W = 7;
	localparam int EXT_W = (MAX_NODES > MASK_W) ? MAX_NODES : MASK_W;
	localparam logic [MAX_NODES-1:0] BIT0 = MAX_NODES'(1);

	entry_t table_q [MAX_NODES];
	logic [MAX_NODES-1:0] flag_q;
	logic [MAX_NODES-1:0] offline_q;
	logic                 first_done_q;
	logic [CNT_W-1:0]     miss_limit_q;
	logic [CNT_W-1:0]     rounds_limit_q;
	logic [IDX_W-1:0]     cnt_q;

	logic             req_q;
	logic [ID_W-1:0]  id_q;
	logic [EV_W-1:0]  ev_q;
	logic             cok_q;

	logic             out_valid_q;
	logic [ID_W-1:0]  out_node_q;
	entry_t           out_ent_q;
	logic             out_rev_q;
	logic [MASK_W-1:0] out_off_q;
	logic [MASK_W-1:0] out_evm_q;

	logic [CMP_W-1:0] id_ext;
	logic [CMP_W-1:0] id_m1;
	logic             bad_id;
	logic [IDX_W-1:0] ev_idx;
	logic [IDX_W-1:0] addr;
	entry_t           cur;
	entry_t           ev_upd;
	entry_t           walk_upd;
	logic             ev_rev;
	logic [MAX_NODES-1:0] node_bit;
	logic [MAX_NODES-1:0] flag_ev;
	logic [MAX_NODES-1:0] flag_walk;
	logic             walk_timeout;
	logic [CNT_W-1:0] miss_sat;
	logic [CNT_W-1:0] silent_sat;
	logic             slot_free;
	logic [EXT_W-1:0] flag_ev_ext;
	logic [EXT_W-1:0] flag_ext;
	logic [EXT_W-1:0] off_ext;

	assign id_ext   = CMP_W'(id_q);
	assign id_m1    = id_ext - CMP_W'(1);
	assign bad_id   = (id_q == '0) || (id_ext > CMP_W'(MAX_NODES));
	assign ev_idx   = id_m1[IDX_W-1:0];
	assign addr     = cmd.walk_step ? cnt_q : ev_idx;
	assign cur      = table_q[addr];
	assign node_bit = BIT0 << addr;

	assign miss_sat   = (cur.miss == CNT_MAX) ? CNT_MAX : cur.miss + CNT_W'(1);
	assign silent_sat = (cur.silent == CNT_MAX) ? CNT_MAX : cur.silent + CNT_W'(1);

	always_comb begin
		ev_upd = cur;
		ev_rev = 1'b0;
		flag_ev = flag_q;
		if (ev_q == EV_DATA || ev_q == EV_CERT) ev_upd.registered = 1'b1;
		if (ev_upd.registered) begin
			case (ev_q)
				EV_PONG_APP, EV_PONG_BOOT, EV_DATA, EV_CERT: begin
					ev_rev = !cur.alive;
					ev_upd.alive = 1'b1;
					ev_upd.mode = (ev_q == EV_PONG_BOOT) ? MODE_BOOT : MODE_APP;
					if (ev_q != EV_CERT) ev_upd.service = (ev_q != EV_PONG_BOOT);
					ev_upd.miss = '0;
					ev_upd.responded = 1'b1;
					if (ev_q == EV_CERT) begin
						ev_upd.cert = 1'b1;
						ev_upd.logged_in = 1'b0;
						ev_upd.login_wait = cok_q;
						ev_upd.logout_wait = 1'b0;
					end else if (!cur.alive && cur.cert && !cur.logged_in) begin
						ev_upd.login_wait = 1'b1;
					end
					if (ev_q == EV_DATA) flag_ev = flag_q | node_bit;
				end
				EV_DATA_MISS: begin
					if (cur.alive) begin
						ev_upd.miss = miss_sat;
						if (miss_sat >= miss_limit_q) ev_upd.service = 1'b0;
					end
				end
				EV_LOGIN_DONE: begin
					ev_upd.logged_in = 1'b1;
					ev_upd.login_wait = 1'b0;
				end
				default: begin
					ev_upd = cur;
				end
			endcase
		end
	end

	always_comb begin
		walk_upd = cur;
		walk_timeout = 1'b0;
		flag_walk = flag_q;
		if (cur.registered && cur.alive) begin
			if (cur.responded) begin
				walk_upd.silent = '0;
			end else if (silent_sat >= rounds_limit_q) begin
				walk_timeout = 1'b1;
				walk_upd.alive = 1'b0;
				walk_upd.service = 1'b0;
				walk_upd.miss = '0;
				walk_upd.silent = '0;
				walk_upd.login_wait = 1'b0;
				if (cur.logged_in) begin
					walk_upd.logout_wait = 1'b1;
					walk_upd.logged_in = 1'b0;
				end
				flag_walk = flag_q & ~node_bit;
			end else begin
				walk_upd.silent = silent_sat;
			end
		end
		walk_upd.responded = 1'b0;
	end

	assign slot_free = !out_valid_q || !out_stall;

	assign status.req_round  = (req_q == REQ_ROUND);
	assign status.first_done = first_done_q;
	assign status.walk_last  = (cnt_q == IDX_W'(MAX_NODES - 1));
	assign status.slot_free  = slot_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < MAX_NODES; k++) table_q[k] <= '0;
			flag_q <= '0;
			first_done_q <= 1'b0;
			miss_limit_q <= LIMIT_RESET;
			rounds_limit_q <= LIMIT_RESET;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid && cfg_index == CFG_DATA_MISS_LIMIT) miss_limit_q <= cfg_data;
			if (cfg_valid && cfg_index == CFG_MISSED_ROUNDS_LIMIT) rounds_limit_q <= cfg_data;
			if (cmd.first_round) begin
				first_done_q <= 1'b1;
				for (int k = 0; k < MAX_NODES; k++) table_q[k].responded <= 1'b0;
			end
			if (cmd.apply_event && !bad_id) begin
				table_q[addr] <= ev_upd;
				flag_q <= flag_ev;
			end
			if (cmd.walk_step) begin
				table_q[addr] <= walk_upd;
				flag_q <= flag_walk;
			end
			if (cmd.apply_event || cmd.load_round) out_valid_q <= 1'b1;
			else if (!out_stall) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			req_q <= req_type;
			id_q  <= node_id;
			ev_q  <= event_code;
			cok_q <= cert_ok;
		end
		if (cmd.walk_start || cmd.first_round) begin
			cnt_q <= '0;
			offline_q <= '0;
		end else if (cmd.walk_step) begin
			cnt_q <= cnt_q + IDX_W'(1);
			if (walk_timeout) offline_q <= offline_q | node_bit;
		end
	end

	assign flag_ev_ext = EXT_W'(bad_id ? flag_q : flag_ev);
	assign flag_ext    = EXT_W'(flag_q);
	assign off_ext     = EXT_W'(offline_q);

	always_ff @(posedge clk) begin
		if (cmd.apply_event) begin
			out_node_q <= id_q;
			out_ent_q  <= bad_id ? '0 : ev_upd;
			out_rev_q  <= !bad_id && ev_rev;
			out_off_q  <= '0;
			out_evm_q  <= flag_ev_ext[MASK_W-1:0];
		end else if (cmd.load_round) begin
			out_node_q <= '0;
			out_ent_q  <= '0;
			out_rev_q  <= 1'b0;
			out_off_q  <= off_ext[MASK_W-1:0];
			out_evm_q  <= flag_ext[MASK_W-1:0];
		end
	end

	assign out_valid      = out_valid_q;
	assign out_node       = out_node_q;
	assign link_alive     = out_ent_q.alive;
	assign node_mode      = out_ent_q.mode;
	assign service_online = out_ent_q.service;
	assign login_pending  = out_ent_q.login_wait;
	assign logout_pending = out_ent_q.logout_wait;
	assign cert_seen      = out_ent_q.cert;
	assign revived        = out_rev_q;
	assign offline_mask   = out_off_q;
	assign event_mask     = out_evm_q;

endmodule

// File: rtl/node_liveness_table_unit.sv
// Node liveness table, top level: joins the controller and the datapath.
// Depends on nlt_pkg, nlt_ctrl and nlt_dp.
//
// Input channel (in_valid / in_stall): one item is a node event (req_type 0,
// node_id 1..MAX_NODES, event_code, cert_ok) or a polling round-end tick
// (req_type 1). Each item yields exactly one result item on the output
// channel (out_valid / out_stall), in order.
// Config channel (cfg_valid / cfg_ready, always ready): index 0 writes
// data_miss_limit, index 1 writes missed_rounds_limit; other indexes ignored.
// Write it only while the block is idle.
// A node event passes the decode and event states before its result is registered.
// A round-end tick walks the table, visiting one table entry per cycle through
// the single table port; the first round end after reset skips the walk.
// A new item is accepted once the previous result sits in the output register.
// If the receiver stalls, the result holds in the output register; the next
// item is processed but its result waits until the register frees up.
// Reset clears the whole table, the event mask and the round history at once,
// and both limits return to 3.
`timescale 1ns / 1ps

module node_liveness_table_unit #(
	parameter int MAX_NODES = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic                          req_type,
	input  logic [nlt_pkg::ID_W-1:0]      node_id,
	input  logic [nlt_pkg::EV_W-1:0]      event_code,
	input  logic                          cert_ok,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [nlt_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [nlt_pkg::CNT_W-1:0]     cfg_data,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [nlt_pkg::ID_W-1:0]      out_node,
	output logic                          link_alive,
	output logic [nlt_pkg::MODE_W-1:0]    node_mode,
	output logic                          service_online,
	output logic                          login_pending,
	output logic                          logout_pending,
	output logic                          cert_seen,
	output logic                          revived,
	output logic [nlt_pkg::MASK_W-1:0]    offline_mask,
	output logic [nlt_pkg::MASK_W-1:0]    event_mask
);
	import nlt_pkg::*;

	dp_cmd_t    cmd;
	dp_status_t status;

	assign cfg_ready = 1'b1;

	nlt_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.status   (status),
		.cmd      (cmd)
	);

	nlt_dp #(
		.MAX_NODES (MAX_NODES)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.status         (status),
		.req_type       (req_type),
		.node_id        (node_id),
		.event_code     (event_code),
		.cert_ok        (cert_ok),
		.cfg_valid      (cfg_valid && cfg_ready),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.out_stall      (out_stall),
		.out_valid      (out_valid),
		.out_node       (out_node),
		.link_alive     (link_alive),
		.node_mode      (node_mode),
		.service_online (service_online),
		.login_pending  (login_pending),
		.logout_pending (logout_pending),
		.cert_seen      (cert_seen),
		.revived        (revived),
		.offline_mask   (offline_mask),
		.event_mask     (event_mask)
	);

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input accepted while an item was still in progress");

	a_event_no_offline: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_node != '0 |-> offline_mask == '0)
		else $error("node event result carries an offline mask");

	a_round_fields_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_node == '0 |-> !revived && !link_alive && node_mode == MODE_UNKNOWN)
		else $error("round-end result carries per-node fields");

endmodule
